### rtl/ramr_pkg.sv
package ramr_pkg;

   localparam int unsigned MODE_WIDTH = 2;
   localparam int unsigned NUM_WIDTH  = 33;
   localparam int unsigned DEN_WIDTH  = 31;
   localparam int unsigned WORK_WIDTH = 64;
   localparam int unsigned STEP_WIDTH = 7;

   typedef enum logic [1:0] {
      MODE_MAKE = 2'd0,
      MODE_ADD  = 2'd1,
      MODE_MUL  = 2'd2,
      MODE_RSVD = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_CHECK,
      ST_REM_START,
      ST_REM_WAIT,
      ST_REM_NEXT,
      ST_QN_START,
      ST_QN_WAIT,
      ST_QD_START,
      ST_QD_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic div_start;
      logic div_sel_rem;
      logic div_sel_qn;
      logic euclid_shift;
      logic take_qn;
      logic take_qd;
      logic set_zero;
      logic set_error;
      logic finish;
      logic out_take;
   } cmd_type;

   typedef struct packed {
      logic rd_zero;
      logic rn_zero;
      logic div_busy;
      logic rem_zero;
      logic out_full;
   } status_type;

endpackage

### rtl/ramr_if.sv
interface ramr_req_if #(parameter int OPERAND_WIDTH = 16);
   logic                             valid;
   logic                             ready;
   logic [ramr_pkg::MODE_WIDTH-1:0]  mode;
   logic signed [OPERAND_WIDTH-1:0]  num_a;
   logic signed [OPERAND_WIDTH-1:0]  den_a;
   logic signed [OPERAND_WIDTH-1:0]  num_b;
   logic signed [OPERAND_WIDTH-1:0]  den_b;
   modport source (output valid, mode, num_a, den_a, num_b, den_b, input ready);
   modport sink (input valid, mode, num_a, den_a, num_b, den_b, output ready);
endinterface

interface ramr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ramr_pkg::NUM_WIDTH-1:0]  res_num;
   logic [ramr_pkg::DEN_WIDTH-1:0]         res_den;
   logic                                   zero_den_error;
   modport source (output valid, res_num, res_den, zero_den_error, input ready);
   modport sink (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

### rtl/rational_add_multiply_reduce_top.sv
// Rational add/multiply with gcd reduction (make mode reduces num_a/den_a alone). One
// transaction at a time: a zero result or a zero denominator finishes without the divider,
// otherwise Euclid remainder divisions (at least one) run before the two final quotients;
// each remainder and each final quotient runs through a single 64-step restoring
// divider. A finished result waits in the output register until it is taken; while the
// previous result still waits, the next one is held back and the input stays blocked.
module rational_add_multiply_reduce_top #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   ramr_req_if.sink   req,
   ramr_rsp_if.source rsp
);
   ramr_pkg::cmd_type    cmd;
   ramr_pkg::status_type status;

   ramr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ramr_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req    (req),
      .rsp    (rsp)
   );
endmodule

### rtl/ramr_div.sv
module ramr_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ramr_pkg::WORK_WIDTH-1:0]     dividend,
   input  logic [ramr_pkg::WORK_WIDTH-1:0]     divisor,
   output logic                                busy,
   output logic [ramr_pkg::WORK_WIDTH-1:0]     quotient,
   output logic [ramr_pkg::WORK_WIDTH-1:0]     remainder
);
   localparam int unsigned W = ramr_pkg::WORK_WIDTH;

   logic [W-1:0]                       quo_ff, quo_in;
   logic [W:0]                         rem_ff, rem_in;
   logic [W-1:0]                       dsr_ff, dsr_in;
   logic [ramr_pkg::STEP_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                               busy_ff, busy_in;
   logic [W:0]                         trial;
   logic [W:0]                         shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ramr_pkg::STEP_WIDTH'(W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[W-1:0];
endmodule

### rtl/ramr_datapath.sv
module ramr_datapath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ramr_pkg::cmd_type      cmd,
   output ramr_pkg::status_type   status,
   ramr_req_if.sink               req,
   ramr_rsp_if.source             rsp
);
   localparam int unsigned W = ramr_pkg::WORK_WIDTH;

   logic [ramr_pkg::MODE_WIDTH-1:0]  mode_ff;
   logic [W-1:0] na_ff, da_ff, nb_ff, db_ff;
   logic [W-1:0] p1_ff, p2_ff, p3_ff;
   logic [W-1:0] rn, rd, mn, md;
   logic [W-1:0] a_ff, b_ff, g_ff, qn_ff, qd_ff;
   logic         neg_ff;
   logic [W-1:0] div_a, div_b, quo, rem;
   logic         div_busy;
   logic         out_valid_ff;
   logic [ramr_pkg::NUM_WIDTH-1:0] out_num_ff;
   logic [ramr_pkg::DEN_WIDTH-1:0] out_den_ff;
   logic         out_err_ff;
   logic [W-1:0] qn_signed;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req.mode;
         na_ff   <= {{(W-OPERAND_WIDTH){req.num_a[OPERAND_WIDTH-1]}}, req.num_a};
         da_ff   <= {{(W-OPERAND_WIDTH){req.den_a[OPERAND_WIDTH-1]}}, req.den_a};
         nb_ff   <= {{(W-OPERAND_WIDTH){req.num_b[OPERAND_WIDTH-1]}}, req.num_b};
         db_ff   <= {{(W-OPERAND_WIDTH){req.den_b[OPERAND_WIDTH-1]}}, req.den_b};
      end
      if (cmd.mul1) begin
         p1_ff <= W'(na_ff[31:0] * db_ff[31:0]);
         p2_ff <= W'(da_ff[31:0] * db_ff[31:0]);
      end
      if (cmd.mul2) begin
         p3_ff <= (mode_ff == ramr_pkg::MODE_ADD) ? W'(da_ff[31:0] * nb_ff[31:0])
                                                  : W'(na_ff[31:0] * nb_ff[31:0]);
      end
   end

   // Unsigned 32x32 products, sign-corrected, give the low 64 bits of the signed product
   logic [W-1:0] sp1, sp2, sp3;
   always_comb begin
      sp1 = p1_ff - ({W{1'b0}} | ((na_ff[W-1] ? {db_ff[31:0], 32'd0} : '0)))
                  - ((db_ff[W-1] ? {na_ff[31:0], 32'd0} : '0));
      sp2 = p2_ff - ((da_ff[W-1] ? {db_ff[31:0], 32'd0} : '0))
                  - ((db_ff[W-1] ? {da_ff[31:0], 32'd0} : '0));
      if (mode_ff == ramr_pkg::MODE_ADD)
         sp3 = p3_ff - ((da_ff[W-1] ? {nb_ff[31:0], 32'd0} : '0))
                     - ((nb_ff[W-1] ? {da_ff[31:0], 32'd0} : '0));
      else
         sp3 = p3_ff - ((na_ff[W-1] ? {nb_ff[31:0], 32'd0} : '0))
                     - ((nb_ff[W-1] ? {na_ff[31:0], 32'd0} : '0));
   end

   always_comb begin
      unique case (mode_ff)
         ramr_pkg::MODE_ADD: begin
            rn = sp1 + sp3;
            rd = sp2;
         end
         ramr_pkg::MODE_MUL: begin
            rn = sp3;
            rd = sp2;
         end
         default: begin
            rn = na_ff;
            rd = da_ff;
         end
      endcase
      mn = rn[W-1] ? (W'(0) - rn) : rn;
      md = rd[W-1] ? (W'(0) - rd) : rd;
   end

   // Euclid state: a_ff/b_ff hold the operands of the current remainder
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= 1'b0;
      end
      if (cmd.take_qn) qn_ff <= quo;
      if (cmd.take_qd) qd_ff <= quo;
      if (cmd.euclid_shift) begin
         a_ff <= b_ff;
         b_ff <= rem;
      end
      if (cmd.set_zero) begin
         a_ff   <= mn;
         b_ff   <= md;
         g_ff   <= md;
         neg_ff <= rn[W-1] ^ rd[W-1];
      end
      if (cmd.div_sel_qn && cmd.div_start) g_ff <= b_ff;
   end

   always_comb begin
      if (cmd.div_sel_rem) begin
         div_a = a_ff;
         div_b = b_ff;
      end else if (cmd.div_sel_qn) begin
         div_a = a_ff;
         div_b = b_ff;
      end else begin
         div_a = md;
         div_b = g_ff;
      end
   end

   ramr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (cmd.div_sel_qn ? mn : div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .quotient  (quo),
      .remainder (rem)
   );

   assign qn_signed = neg_ff ? (W'(0) - qn_ff) : qn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         if (cmd.set_error) begin
            out_num_ff <= '0;
            out_den_ff <= '0;
            out_err_ff <= 1'b1;
         end else if (cmd.out_take) begin
            out_num_ff <= '0;
            out_den_ff <= ramr_pkg::DEN_WIDTH'(1);
            out_err_ff <= 1'b0;
         end else begin
            out_num_ff <= qn_signed[ramr_pkg::NUM_WIDTH-1:0];
            out_den_ff <= qd_ff[ramr_pkg::DEN_WIDTH-1:0];
            out_err_ff <= 1'b0;
         end
      end
   end

   assign status.rd_zero  = (rd == '0);
   assign status.rn_zero  = (mn == '0);
   assign status.div_busy = div_busy;
   assign status.rem_zero = (rem == '0);
   assign status.out_full = out_valid_ff && !rsp.ready;

   assign rsp.valid          = out_valid_ff;
   assign rsp.res_num        = out_num_ff;
   assign rsp.res_den        = out_den_ff;
   assign rsp.zero_den_error = out_err_ff;
endmodule

### rtl/ramr_ctrl.sv
module ramr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ramr_pkg::status_type   status,
   output ramr_pkg::cmd_type      cmd
);
   ramr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ramr_pkg::ST_IDLE:      if (req_valid) state_in = ramr_pkg::ST_MUL1;
         ramr_pkg::ST_MUL1:      state_in = ramr_pkg::ST_MUL2;
         ramr_pkg::ST_MUL2:      state_in = ramr_pkg::ST_CHECK;
         ramr_pkg::ST_CHECK: begin
            if (status.rd_zero || status.rn_zero) begin
               if (!status.out_full) state_in = ramr_pkg::ST_IDLE;
            end else begin
               state_in = ramr_pkg::ST_REM_START;
            end
         end
         ramr_pkg::ST_REM_START: state_in = ramr_pkg::ST_REM_WAIT;
         ramr_pkg::ST_REM_WAIT:  if (!status.div_busy) state_in = ramr_pkg::ST_REM_NEXT;
         ramr_pkg::ST_REM_NEXT:  state_in = status.rem_zero ? ramr_pkg::ST_QN_START
                                                          : ramr_pkg::ST_REM_START;
         ramr_pkg::ST_QN_START:  state_in = ramr_pkg::ST_QN_WAIT;
         ramr_pkg::ST_QN_WAIT:   if (!status.div_busy) state_in = ramr_pkg::ST_QD_START;
         ramr_pkg::ST_QD_START:  state_in = ramr_pkg::ST_QD_WAIT;
         ramr_pkg::ST_QD_WAIT:   if (!status.div_busy) state_in = ramr_pkg::ST_DONE;
         ramr_pkg::ST_DONE:      if (!status.out_full) state_in = ramr_pkg::ST_IDLE;
         default:                state_in = ramr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ramr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ramr_pkg::ST_MUL1: cmd.mul1 = 1'b1;
         ramr_pkg::ST_MUL2: cmd.mul2 = 1'b1;
         ramr_pkg::ST_CHECK: begin
            cmd.set_zero = 1'b1;
            if (status.rd_zero) begin
               cmd.set_error = 1'b1;
               cmd.finish    = !status.out_full;
            end else if (status.rn_zero) begin
               cmd.out_take = 1'b1;
               cmd.finish   = !status.out_full;
            end
         end
         ramr_pkg::ST_REM_START: begin
            cmd.div_start   = 1'b1;
            cmd.div_sel_rem = 1'b1;
         end
         ramr_pkg::ST_REM_NEXT: cmd.euclid_shift = !status.rem_zero;
         ramr_pkg::ST_QN_START: begin
            cmd.div_start  = 1'b1;
            cmd.div_sel_qn = 1'b1;
         end
         ramr_pkg::ST_QN_WAIT:  cmd.take_qn = !status.div_busy;
         ramr_pkg::ST_QD_START: cmd.div_start = 1'b1;
         ramr_pkg::ST_QD_WAIT:  cmd.take_qd = !status.div_busy;
         ramr_pkg::ST_DONE:     cmd.finish = !status.out_full;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ramr_pkg::ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

### tb/sv/ramr_tb_if.sv
`timescale 1ns / 100ps
// Interfaces are provided by rtl/ramr_if.sv; this file holds testbench item types.
package ramr_tb_pkg;

   typedef struct {
      ramr_pkg::mode_type mode;
      logic signed [15:0] num_a;
      logic signed [15:0] den_a;
      logic signed [15:0] num_b;
      logic signed [15:0] den_b;
   } fraction_op_type;

   typedef struct {
      logic signed [ramr_pkg::NUM_WIDTH-1:0] res_num;
      logic [ramr_pkg::DEN_WIDTH-1:0]        res_den;
      logic                                  zero_den_error;
   } fraction_res_type;
endpackage

### tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;

   localparam int LIMIT = 20000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   errors = 0;
   bit   calm = 1'b0;
   bit   stim_done = 1'b0;

   ramr_tb_pkg::fraction_op_type  pending_ops[$];
   ramr_tb_pkg::fraction_res_type expected_fracs[$];

   ramr_req_if #(.OPERAND_WIDTH(16)) req ();
   ramr_rsp_if rsp ();

   rational_add_multiply_reduce_top #(.OPERAND_WIDTH(16)) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic ramr_tb_pkg::fraction_res_type reduce_fraction(
      ramr_tb_pkg::fraction_op_type op);
      ramr_tb_pkg::fraction_res_type r;
      longint n, d, mn, md, a, b, t;
      case (op.mode)
         ramr_pkg::MODE_ADD: begin
            n = longint'(op.num_a) * op.den_b + longint'(op.den_a) * op.num_b;
            d = longint'(op.den_a) * op.den_b;
         end
         ramr_pkg::MODE_MUL: begin
            n = longint'(op.num_a) * op.num_b;
            d = longint'(op.den_a) * op.den_b;
         end
         default: begin
            n = op.num_a;
            d = op.den_a;
         end
      endcase
      r.zero_den_error = 1'b0;
      if (d == 0) begin
         r.res_num = '0;
         r.res_den = '0;
         r.zero_den_error = 1'b1;
      end else if (n == 0) begin
         r.res_num = '0;
         r.res_den = ramr_pkg::DEN_WIDTH'(1);
      end else begin
         mn = (n < 0) ? -n : n;
         md = (d < 0) ? -d : d;
         a = mn;
         b = md;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         mn = mn / a;
         md = md / a;
         if ((n < 0) != (d < 0)) mn = -mn;
         r.res_num = mn[ramr_pkg::NUM_WIDTH-1:0];
         r.res_den = md[ramr_pkg::DEN_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(int'($urandom_range(0, 6)) - 3);
         3: return 16'(int'($urandom_range(0, 200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_op(ramr_pkg::mode_type m, int na, int da, int nb, int db);
      ramr_tb_pkg::fraction_op_type op;
      op.mode = m;
      op.num_a = 16'(na);
      op.den_a = 16'(da);
      op.num_b = 16'(nb);
      op.den_b = 16'(db);
      pending_ops.push_back(op);
   endtask

   initial begin
      ramr_tb_pkg::fraction_op_type op;
      queue_op(ramr_pkg::MODE_MAKE, 6, -4, 99, 0);
      queue_op(ramr_pkg::MODE_MAKE, 5, 0, 1, 1);
      queue_op(ramr_pkg::MODE_MAKE, 0, -7, 1, 1);
      queue_op(ramr_pkg::MODE_MAKE, -32768, -32768, 0, 0);
      queue_op(ramr_pkg::MODE_MAKE, 32767, -32768, 0, 0);
      queue_op(ramr_pkg::MODE_RSVD, -12, 18, 5, 0);
      queue_op(ramr_pkg::MODE_ADD, 1, 2, 1, 3);
      queue_op(ramr_pkg::MODE_ADD, 1, 2, -1, 2);
      queue_op(ramr_pkg::MODE_ADD, 1, 0, 1, 2);
      queue_op(ramr_pkg::MODE_ADD, -32768, 32767, -32768, 32767);
      queue_op(ramr_pkg::MODE_ADD, 32767, -32768, 32767, -32768);
      queue_op(ramr_pkg::MODE_ADD, -32768, -1, -32768, -1);
      queue_op(ramr_pkg::MODE_MUL, -32768, 1, -32768, 1);
      queue_op(ramr_pkg::MODE_MUL, 32767, -32768, 32767, -32768);
      queue_op(ramr_pkg::MODE_MUL, 0, 5, 3, 7);
      queue_op(ramr_pkg::MODE_MUL, 3, 4, 5, 0);
      queue_op(ramr_pkg::MODE_MUL, -1, -1, -1, -1);
      queue_op(ramr_pkg::MODE_MAKE, 16'hffff, 16'h5555, 16'haaaa, 16'hffff);
      repeat (1000) begin
         op.mode = ramr_pkg::mode_type'($urandom_range(0, 3));
         op.num_a = pick_operand();
         op.den_a = pick_operand();
         op.num_b = pick_operand();
         op.den_b = pick_operand();
         pending_ops.push_back(op);
      end
      stim_done = 1'b1;
   end

   function automatic void op_accept();
      ramr_tb_pkg::fraction_op_type op;
      op.mode = ramr_pkg::mode_type'(req.mode);
      op.num_a = req.num_a;
      op.den_a = req.den_a;
      op.num_b = req.num_b;
      op.den_b = req.den_b;
      expected_fracs.push_back(reduce_fraction(op));
      void'(pending_ops.pop_front());
      if (pending_ops.size() < 150) calm = 1'b1;
   endfunction

   // driver
   int req_idle = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            op_accept();
         end
         if (!req.valid || req.ready) begin
            if (req_idle > 0) begin
               req_idle <= req_idle - 1;
               req.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               req_idle <= $urandom_range(0, 10);
               req.valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               req.valid <= 1'b1;
               req.mode  <= pending_ops[0].mode;
               req.num_a <= pending_ops[0].num_a;
               req.den_a <= pending_ops[0].den_a;
               req.num_b <= pending_ops[0].num_b;
               req.den_b <= pending_ops[0].den_b;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int rsp_idle = 0;
   always @(posedge clock) begin
      ramr_tb_pkg::fraction_res_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_fracs.size() == 0) begin
               $error("unexpected transaction num=%0d den=%0d", rsp.res_num, rsp.res_den);
               errors++;
            end else begin
               want = expected_fracs.pop_front();
               if (rsp.res_num !== want.res_num) begin
                  $error("res_num exp %0d got %0d", want.res_num, rsp.res_num);
                  errors++;
               end
               if (rsp.res_den !== want.res_den) begin
                  $error("res_den exp %0d got %0d", want.res_den, rsp.res_den);
                  errors++;
               end
               if (rsp.zero_den_error !== want.zero_den_error) begin
                  $error("zero_den_error exp %0b got %0b", want.zero_den_error,
                         rsp.zero_den_error);
                  errors++;
               end
            end
         end
         if (rsp_idle > 0) begin
            rsp_idle <= rsp_idle - 1;
            rsp.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_idle <= $urandom_range(0, 10);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.mode = '0;
      req.num_a = '0;
      req.den_a = '0;
      req.num_b = '0;
      req.den_b = '0;
      rsp.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && pending_ops.size() == 0 && !req.valid &&
               expected_fracs.size() == 0))
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end
endmodule

### filelist.f
rtl/ramr_pkg.sv
rtl/ramr_if.sv
rtl/ramr_div.sv
rtl/ramr_datapath.sv
rtl/ramr_ctrl.sv
rtl/rational_add_multiply_reduce_top.sv
tb/sv/ramr_tb_if.sv
tb/sv/testbench.sv
